/* design/cdq_pkg.sv */
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants of the circular deque: operation and status
// codes, field widths and the per-operation result record.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

   // width of the capacity register and of the fill count
   localparam int unsigned CNT_W = 9;
   // width of the element ports
   localparam int unsigned VAL_W = 32;

   // operation codes carried by req_func
   typedef enum logic [1:0] {
      FUNC_PUSH_BACK  = 2'd0,
      FUNC_PUSH_FRONT = 2'd1,
      FUNC_POP_BACK   = 2'd2,
      FUNC_POP_FRONT  = 2'd3
   } func_type;

   // status codes returned on rsp_status
   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   // per-operation outcome handed from the controller to the output pipeline
   typedef struct packed {
      logic               pop_ok;
      status_type         status;
      logic [CNT_W-1:0]   fill_count;
   } result_type;

endpackage : cdq_pkg

`default_nettype wire

/* design/circular_deque.sv */
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue held in a ring of RAM entries with a programmable
// capacity.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one operation per transfer (req_func selects push back,
//   push front, pop back or pop front; req_push_value is stored on pushes).
//   rsp_ channel: exactly one result per operation, in order: the popped
//   element (zero on pushes and refused pops), a status (done, refused
//   full, refused empty) and the number of elements held afterwards.
//   csr_ channel: writes the capacity (1..DEPTH, zero acts as 1, larger
//   values act as DEPTH); a write empties the deque. It is ready only
//   while no operation is in flight.
//   Throughput: one operation per cycle while req_stall is low. Each
//   operation is at most one access to the single RAM port; pointers and
//   count update at the transfer, so the next operation sees them in the
//   following cycle. Response path: RAM read data and result record are
//   registered at the transfer edge, and the output register loads from
//   them once it is free; rsp_valid then rises.
//   Reset: empty deque, capacity min(256, DEPTH); no clearing pass.
//   When rsp_stall is high the output register and one more result are
//   held, after which req_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_deque #(
   parameter int unsigned DEPTH      = 256,
   parameter int unsigned DATA_WIDTH = 32
) (
   input  wire                           clock,
   input  wire                           reset,
   // request channel
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire [1:0]                     req_func,
   input  wire [cdq_pkg::VAL_W-1:0]      req_push_value,
   // response channel
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output logic [cdq_pkg::VAL_W-1:0]     rsp_pop_value,
   output logic [1:0]                    rsp_status,
   output logic [cdq_pkg::CNT_W-1:0]     rsp_fill_count,
   // capacity register write
   input  wire                           csr_valid,
   output logic                          csr_ready,
   input  wire [cdq_pkg::CNT_W-1:0]      csr_data
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned MW = (DATA_WIDTH > cdq_pkg::VAL_W) ? cdq_pkg::VAL_W : DATA_WIDTH;

   logic                       accept;
   logic                       cap_wr;
   logic                       mem_wr_en, mem_rd_en;
   logic [AW-1:0]              mem_addr;
   logic [MW-1:0]              mem_wdata, mem_rdata;
   cdq_pkg::result_type        result;

   logic                       s1_valid_ff, s1_valid_in;
   cdq_pkg::result_type        s1_res_ff,   s1_res_in;
   logic                       s1_move;
   logic                       out_valid_ff, out_valid_in;
   logic [cdq_pkg::VAL_W-1:0]  out_value_ff, out_value_in;
   cdq_pkg::status_type        out_status_ff, out_status_in;
   logic [cdq_pkg::CNT_W-1:0]  out_count_ff, out_count_in;

   // handshakes
   assign s1_move   = !out_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_move;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = !s1_valid_ff && !out_valid_ff;
   assign cap_wr    = csr_valid && csr_ready;

   // pointer and count bookkeeping
   cdq_ctrl #(
      .DEPTH (DEPTH),
      .MW    (MW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cap_wr     (cap_wr),
      .cap_data   (csr_data),
      .accept     (accept),
      .func       (req_func),
      .push_value (req_push_value),
      .mem_wr_en  (mem_wr_en),
      .mem_rd_en  (mem_rd_en),
      .mem_addr   (mem_addr),
      .mem_wdata  (mem_wdata),
      .result     (result)
   );

   // ring store
   cdq_ram #(
      .WIDTH (MW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .wr_en (mem_wr_en),
      .rd_en (mem_rd_en),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   // read stage and output register
   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_res_in     = s1_res_ff;
      out_valid_in  = out_valid_ff;
      out_value_in  = out_value_ff;
      out_status_in = out_status_ff;
      out_count_in  = out_count_ff;
      if (s1_move) begin
         out_valid_in  = s1_valid_ff;
         out_value_in  = s1_res_ff.pop_ok ? cdq_pkg::VAL_W'(mem_rdata) : '0;
         out_status_in = s1_res_ff.status;
         out_count_in  = s1_res_ff.fill_count;
         s1_valid_in   = 1'b0;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_res_in   = result;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_res_ff     <= s1_res_in;
      out_value_ff  <= out_value_in;
      out_status_ff <= out_status_in;
      out_count_ff  <= out_count_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_pop_value  = out_value_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_fill_count = out_count_ff;

endmodule : circular_deque

`default_nettype wire

/* design/cdq_ram.sv */
// ----------------------------------------------------------------------------
// cdq_ram
// Generic single-port synchronous RAM with registered read data. The read
// register holds its value on cycles without a read.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire                      rd_en,
   input  wire [$clog2(DEPTH)-1:0]  addr,
   input  wire [WIDTH-1:0]          wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wdata;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule : cdq_ram

`default_nettype wire

/* design/cdq_ctrl.sv */
// ----------------------------------------------------------------------------
// cdq_ctrl
// Head, tail and count bookkeeping of the deque. Decodes each accepted
// operation into at most one RAM access and the result record for it.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ctrl #(
   parameter int unsigned DEPTH = 256,
   parameter int unsigned MW    = 32
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              cap_wr,
   input  wire [cdq_pkg::CNT_W-1:0]         cap_data,
   input  wire                              accept,
   input  wire [1:0]                        func,
   input  wire [cdq_pkg::VAL_W-1:0]         push_value,
   output logic                             mem_wr_en,
   output logic                             mem_rd_en,
   output logic [$clog2(DEPTH)-1:0]         mem_addr,
   output logic [MW-1:0]                    mem_wdata,
   output cdq_pkg::result_type              result
);

   localparam int unsigned AW      = $clog2(DEPTH);
   localparam int unsigned CAP_RST = (256 > DEPTH) ? DEPTH : 256;

   logic [cdq_pkg::CNT_W-1:0] cap_ff,   cap_in;
   logic [AW-1:0]             last_ff,  last_in;
   logic [AW-1:0]             head_ff,  head_in;
   logic [AW-1:0]             tail_ff,  tail_in;
   logic [cdq_pkg::CNT_W-1:0] count_ff, count_in;
   logic [cdq_pkg::CNT_W-1:0] cap_clamp;
   logic [AW-1:0]             head_up, head_dn, tail_up, tail_dn;
   logic                      full, empty;

   // clamp a written capacity into 1..DEPTH
   always_comb begin
      cap_clamp = cap_data;
      if (cap_data == '0) begin
         cap_clamp = cdq_pkg::CNT_W'(1);
      end else if (32'(cap_data) > 32'(DEPTH)) begin
         cap_clamp = cdq_pkg::CNT_W'(DEPTH);
      end
   end

   // wrapping neighbours of both pointers
   assign head_up = (head_ff == last_ff) ? '0 : head_ff + AW'(1);
   assign head_dn = (head_ff == '0) ? last_ff : head_ff - AW'(1);
   assign tail_up = (tail_ff == last_ff) ? '0 : tail_ff + AW'(1);
   assign tail_dn = (tail_ff == '0) ? last_ff : tail_ff - AW'(1);

   assign full  = (count_ff == cap_ff);
   assign empty = (count_ff == '0);

   // decode of one operation
   always_comb begin
      cap_in            = cap_ff;
      last_in           = last_ff;
      head_in           = head_ff;
      tail_in           = tail_ff;
      count_in          = count_ff;
      mem_wr_en         = 1'b0;
      mem_rd_en         = 1'b0;
      mem_addr          = tail_ff;
      mem_wdata         = push_value[MW-1:0];
      result.pop_ok     = 1'b0;
      result.status     = cdq_pkg::STAT_DONE;
      unique case (cdq_pkg::func_type'(func))
         cdq_pkg::FUNC_PUSH_BACK: begin
            if (full) begin
               result.status = cdq_pkg::STAT_FULL;
            end else begin
               mem_wr_en = accept;
               mem_addr  = tail_ff;
               tail_in   = tail_up;
               count_in  = count_ff + cdq_pkg::CNT_W'(1);
            end
         end
         cdq_pkg::FUNC_PUSH_FRONT: begin
            if (full) begin
               result.status = cdq_pkg::STAT_FULL;
            end else begin
               mem_wr_en = accept;
               mem_addr  = head_dn;
               head_in   = head_dn;
               count_in  = count_ff + cdq_pkg::CNT_W'(1);
            end
         end
         cdq_pkg::FUNC_POP_BACK: begin
            if (empty) begin
               result.status = cdq_pkg::STAT_EMPTY;
            end else begin
               mem_rd_en     = accept;
               mem_addr      = tail_dn;
               tail_in       = tail_dn;
               count_in      = count_ff - cdq_pkg::CNT_W'(1);
               result.pop_ok = 1'b1;
            end
         end
         cdq_pkg::FUNC_POP_FRONT: begin
            if (empty) begin
               result.status = cdq_pkg::STAT_EMPTY;
            end else begin
               mem_rd_en     = accept;
               mem_addr      = head_ff;
               head_in       = head_up;
               count_in      = count_ff - cdq_pkg::CNT_W'(1);
               result.pop_ok = 1'b1;
            end
         end
         default: begin
            result.status = cdq_pkg::STAT_DONE;
         end
      endcase
      result.fill_count = count_in;
      // a capacity write empties the deque
      if (cap_wr) begin
         cap_in   = cap_clamp;
         last_in  = AW'(cap_clamp - cdq_pkg::CNT_W'(1));
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
      end
   end

   // pointer, count and capacity registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= cdq_pkg::CNT_W'(CAP_RST);
         last_ff  <= AW'(CAP_RST - 1);
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (accept || cap_wr) begin
         cap_ff   <= cap_in;
         last_ff  <= last_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule : cdq_ctrl

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for circular_deque. Queued deque operations are sent
// through the request channel with random gaps. Each request transfer is run
// through a local model of the ring, head, tail and fill count, and the
// outcome is kept in order. Response transfers are checked against it field
// by field. The capacity register is rewritten between phases, including
// zero, one and values above the ring size.
// ----------------------------------------------------------------------------

module tb;

   localparam int unsigned RING_SLOTS  = 256;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned REPORT_MAX  = 10;
   localparam int unsigned PHASES      = 8;

   typedef struct packed {
      cdq_pkg::func_type             func;
      logic [cdq_pkg::VAL_W-1:0]     value;
   } deque_op_type;

   typedef struct packed {
      logic [cdq_pkg::VAL_W-1:0]     pop_value;
      cdq_pkg::status_type           status;
      logic [cdq_pkg::CNT_W-1:0]     fill_count;
   } deque_outcome_type;

   // dut connections, all inputs known from time zero
   logic                      clock          = 1'b0;
   logic                      reset          = 1'b1;
   logic                      req_valid      = 1'b0;
   logic                      req_stall;
   logic [1:0]                req_func       = '0;
   logic [cdq_pkg::VAL_W-1:0] req_push_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall      = 1'b0;
   logic [cdq_pkg::VAL_W-1:0] rsp_pop_value;
   logic [1:0]                rsp_status;
   logic [cdq_pkg::CNT_W-1:0] rsp_fill_count;
   logic                      csr_valid      = 1'b0;
   logic                      csr_ready;
   logic [cdq_pkg::CNT_W-1:0] csr_data       = '0;

   // stimulus and scoreboard storage
   deque_op_type      pending_ops [$];
   deque_outcome_type outcomes_due [$];
   int unsigned       send_idle_pct  = 0;
   int unsigned       recv_stall_pct = 0;
   int unsigned       mismatch_cnt   = 0;
   int unsigned       cycle_cnt      = 0;

   // local copy of the deque state
   logic [cdq_pkg::VAL_W-1:0] ring_copy [RING_SLOTS];
   int unsigned               front_ptr   = 0;
   int unsigned               back_ptr    = 0;
   int unsigned               held        = 0;
   int unsigned               cap_setting = 256;

   circular_deque u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_status     (rsp_status),
      .rsp_fill_count (rsp_fill_count),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // zero acts as one, anything above the ring size as the ring size
   function automatic int unsigned effective_capacity(input int unsigned raw);
      if (raw == 0) return 1;
      if (raw > RING_SLOTS) return RING_SLOTS;
      return raw;
   endfunction

   // apply one operation to the local deque and return its outcome
   function automatic deque_outcome_type deque_apply(input deque_op_type op);
      int unsigned       cap;
      deque_outcome_type res;
      cap = effective_capacity(cap_setting);
      res.pop_value = '0;
      res.status    = cdq_pkg::STAT_DONE;
      if (op.func == cdq_pkg::FUNC_PUSH_BACK || op.func == cdq_pkg::FUNC_PUSH_FRONT) begin
         if (held >= cap) begin
            res.status = cdq_pkg::STAT_FULL;
         end else if (op.func == cdq_pkg::FUNC_PUSH_BACK) begin
            ring_copy[back_ptr] = op.value;
            back_ptr = (back_ptr + 1 >= cap) ? 0 : back_ptr + 1;
            held++;
         end else begin
            front_ptr = (front_ptr == 0) ? cap - 1 : front_ptr - 1;
            ring_copy[front_ptr] = op.value;
            held++;
         end
      end else begin
         if (held == 0) begin
            res.status = cdq_pkg::STAT_EMPTY;
         end else if (op.func == cdq_pkg::FUNC_POP_BACK) begin
            back_ptr = (back_ptr == 0) ? cap - 1 : back_ptr - 1;
            res.pop_value = ring_copy[back_ptr];
            held--;
         end else begin
            res.pop_value = ring_copy[front_ptr];
            front_ptr = (front_ptr + 1 >= cap) ? 0 : front_ptr + 1;
            held--;
         end
      end
      res.fill_count = cdq_pkg::CNT_W'(held);
      return res;
   endfunction

   // count a failure, print only the first few
   task automatic log_mismatch(input string msg);
      mismatch_cnt++;
      if (mismatch_cnt <= REPORT_MAX) $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
   endtask

   // request driver: model the transfer, then present the next item
   always @(posedge clock) begin : req_driver
      deque_op_type op_taken;
      deque_op_type op_next;
      if (!reset && req_valid && !req_stall) begin
         op_taken.func  = cdq_pkg::func_type'(req_func);
         op_taken.value = req_push_value;
         outcomes_due.push_back(deque_apply(op_taken));
      end
      if (reset || (req_valid && req_stall)) begin
         // held item stays put
      end else if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
         op_next = pending_ops.pop_front();
         req_valid      <= 1'b1;
         req_func       <= op_next.func;
         req_push_value <= op_next.value;
      end else begin
         // idle cycle, payload is noise
         req_valid      <= 1'b0;
         req_func       <= 2'($urandom);
         req_push_value <= $urandom;
      end
   end

   // response monitor: compare each transfer with the oldest outcome
   always @(posedge clock) begin : rsp_monitor
      deque_outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (outcomes_due.size() == 0) begin
            log_mismatch($sformatf("unexpected result value %h status %0d fill %0d",
                                   rsp_pop_value, rsp_status, rsp_fill_count));
         end else begin
            want = outcomes_due.pop_front();
            if (rsp_pop_value !== want.pop_value || rsp_status !== want.status ||
                rsp_fill_count !== want.fill_count)
               log_mismatch($sformatf(
                  "value %h/%h status %0d/%0d fill %0d/%0d (expected/actual)",
                  want.pop_value, rsp_pop_value, want.status, rsp_status,
                  want.fill_count, rsp_fill_count));
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // run limit
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic queue_op(input cdq_pkg::func_type func,
                           input logic [cdq_pkg::VAL_W-1:0] value);
      deque_op_type op;
      op.func  = func;
      op.value = value;
      pending_ops.push_back(op);
   endtask

   // bursts leaning to pushes then to pops, so the fill sweeps empty to full
   task automatic queue_random(input int unsigned count, input int unsigned raw_cap);
      int unsigned cap;
      int unsigned burst_left;
      bit          push_lean;
      bit          is_push;
      cap        = effective_capacity(raw_cap);
      burst_left = 0;
      push_lean  = 1'b0;
      for (int unsigned n = 0; n < count; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 2 * cap + 4);
            push_lean  = !push_lean;
         end
         burst_left--;
         is_push = ($urandom_range(99) < 85) ? push_lean : !push_lean;
         if (is_push)
            queue_op($urandom_range(1) ? cdq_pkg::FUNC_PUSH_FRONT : cdq_pkg::FUNC_PUSH_BACK,
                     $urandom);
         else
            queue_op($urandom_range(1) ? cdq_pkg::FUNC_POP_FRONT : cdq_pkg::FUNC_POP_BACK,
                     $urandom);
      end
   endtask

   // wait until every item is sent and answered, then let the pipe settle
   task automatic wait_for_quiet();
      while (pending_ops.size() != 0 || req_valid || outcomes_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // capacity write, only while the deque is idle; a write empties it
   task automatic write_capacity(input logic [cdq_pkg::CNT_W-1:0] cap);
      csr_valid <= 1'b1;
      csr_data  <= cap;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid   <= 1'b0;
      cap_setting = cap;
      front_ptr   = 0;
      back_ptr    = 0;
      held        = 0;
   endtask

   initial begin : stimulus
      int unsigned phase_caps [PHASES] = '{3, 1, 511, 0, 2, 256, 20, 7};
      int unsigned phase_len  [PHASES] = '{150, 100, 500, 80, 120, 500, 150, 150};
      phase_caps[6] = $urandom_range(4, 40);
      send_idle_pct  = 36;
      recv_stall_pct = 61;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset capacity: pops on empty, value extremes at both ends
      queue_op(cdq_pkg::FUNC_POP_BACK, 32'hFFFF_FFFF);
      queue_op(cdq_pkg::FUNC_POP_FRONT, 32'h0);
      queue_op(cdq_pkg::FUNC_PUSH_BACK, 32'hFFFF_FFFF);
      queue_op(cdq_pkg::FUNC_PUSH_FRONT, 32'h0);
      queue_op(cdq_pkg::FUNC_PUSH_BACK, 32'hAAAA_AAAA);
      queue_op(cdq_pkg::FUNC_PUSH_FRONT, 32'h5555_5555);
      queue_op(cdq_pkg::FUNC_POP_FRONT, 32'h0);
      queue_op(cdq_pkg::FUNC_POP_BACK, 32'h0);
      queue_op(cdq_pkg::FUNC_POP_BACK, 32'h0);
      queue_op(cdq_pkg::FUNC_POP_FRONT, 32'h0);
      queue_op(cdq_pkg::FUNC_POP_FRONT, 32'h0);
      wait_for_quiet();

      // capacity two: fill, refused pushes of both kinds, drain past empty
      write_capacity(2);
      queue_op(cdq_pkg::FUNC_PUSH_BACK, 32'h8000_0000);
      queue_op(cdq_pkg::FUNC_PUSH_FRONT, 32'h0000_0001);
      queue_op(cdq_pkg::FUNC_PUSH_BACK, 32'h1234_5678);
      queue_op(cdq_pkg::FUNC_PUSH_FRONT, 32'h8765_4321);
      queue_op(cdq_pkg::FUNC_POP_BACK, 32'h0);
      queue_op(cdq_pkg::FUNC_POP_FRONT, 32'h0);
      queue_op(cdq_pkg::FUNC_POP_BACK, 32'h0);
      wait_for_quiet();

      // capacity zero behaves as one
      write_capacity(0);
      queue_op(cdq_pkg::FUNC_PUSH_FRONT, 32'hDEAD_BEEF);
      queue_op(cdq_pkg::FUNC_PUSH_BACK, 32'hFFFF_FFFF);
      queue_op(cdq_pkg::FUNC_POP_BACK, 32'h0);
      queue_op(cdq_pkg::FUNC_POP_FRONT, 32'h0);
      wait_for_quiet();

      // random phases over several capacities and idling patterns
      for (int unsigned k = 0; k < PHASES; k++) begin
         if (k == 3) begin
            send_idle_pct  = 61;
            recv_stall_pct = 36;
         end else if (k == 6) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         write_capacity(phase_caps[k]);
         queue_random(phase_len[k], phase_caps[k]);
         wait_for_quiet();
      end

      repeat (8) @(posedge clock);
      if (mismatch_cnt == 0 && outcomes_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
